// File: design/fac_pkg.sv
package fac_pkg;

  localparam int LINES       = 16;
  localparam int BLOCK_WORDS = 8;
  localparam int LINE_W      = $clog2(LINES);
  localparam int WORD_W      = $clog2(BLOCK_WORDS);
  localparam int OFF_W       = WORD_W + 3;
  localparam int MEM_AW      = LINE_W + WORD_W;
  localparam int OUT_AW      = 32;

  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_RESP   = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_BLK_RD = 2'd2,
    KIND_WB     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  port;
    logic [31:0] address;
    logic [7:0]  byte_mask;
    logic [63:0] data;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  out_port;
    logic [31:0] out_address;
    logic [63:0] out_data;
    logic        last;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [7:0]        wbe;
    logic [MEM_AW-1:0] waddr;
    logic [63:0]       wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  function automatic logic [63:0] byte_merge(logic [63:0] old_w, logic [63:0] new_w,
                                             logic [7:0] mask);
    logic [63:0] r;
    r = old_w;
    for (int b = 0; b < 8; b++) begin
      if (mask[b]) r[8*b +: 8] = new_w[8*b +: 8];
    end
    return r;
  endfunction

endpackage

// File: design/fully_assoc_writeback_cache.sv
// Hits, rejects and block reads: one item per cycle while the output is not stalled; each
// item is registered at the input and its result in the output register. A fill beat that
// is not the last goes to the fill buffer and gives no result. The last fill beat holds the
// input while each block word is installed through the line store's single write port, then the response.
// Reset (rst_n low, synchronous) clears line valid bits and miss state and loads the seed.
module fully_assoc_writeback_cache #(
  parameter int CPU_PORTS = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  fac_pkg::in_t            in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output fac_pkg::out_t           out_item,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data
);

  localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W = AW - fac_pkg::OFF_W;
  localparam int LN    = fac_pkg::LINES;
  localparam int BW    = fac_pkg::BLOCK_WORDS;
  localparam int LW    = fac_pkg::LINE_W;
  localparam int WW    = fac_pkg::WORD_W;

  logic                 s1_valid_r, s1_valid_nxt;
  fac_pkg::in_t         s1_r;
  logic                 out_valid_r;
  fac_pkg::out_t        out_r, res;
  logic                 use_mem_r, res_mem;
  logic                 emit, s1_done, s2_free;

  logic [TAG_W-1:0]     tag_r [LN];
  logic [LN-1:0]        valid_r, valid_nxt;
  logic [63:0]          fill_r [BW];
  logic [WW-1:0]        beat_r, beat_nxt;
  logic [WW:0]          seq_r, seq_nxt;
  logic                 miss_r, miss_nxt;
  logic [1:0]           sv_port_r;
  logic                 sv_write_r;
  logic [AW-1:0]        sv_addr_r;
  logic [7:0]           sv_mask_r;
  logic [63:0]          sv_data_r;
  logic [15:0]          lfsr_r, lfsr_nxt, lfsr_step;
  logic                 save_en, fill_en, tag_en;

  fac_pkg::mem_req_t    mreq;
  logic [63:0]          mem_rdata;

  logic [AW-1:0]        addr_m;
  logic [TAG_W-1:0]     tag_in;
  logic                 hit;
  logic [LW-1:0]        hit_idx, free_idx, line_sel;
  logic                 free_found;
  logic [WW-1:0]        k, sv_word;
  logic [63:0]          fill_k, fill_sv, inst_data;
  logic                 is_cpu, port_ok;

  fac_line_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

  assign addr_m    = s1_r.address[AW-1:0];
  assign tag_in    = addr_m[AW-1:fac_pkg::OFF_W];
  assign is_cpu    = (s1_r.opcode == fac_pkg::OP_READ) || (s1_r.opcode == fac_pkg::OP_WRITE);
  assign port_ok   = 32'(s1_r.port) < CPU_PORTS;
  assign s2_free   = !out_valid_r || out_ready;
  assign lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? fac_pkg::LFSR_TAPS : 16'd0);
  assign sv_word   = sv_addr_r[fac_pkg::OFF_W-1:3];
  assign k         = seq_r[WW-1:0];

  // the last beat is still in the input register, not in the fill buffer
  assign fill_k  = (k == WW'(BW - 1)) ? s1_r.data : fill_r[k];
  assign fill_sv = (sv_word == WW'(BW - 1)) ? s1_r.data : fill_r[sv_word];
  assign inst_data = (sv_write_r && (k == sv_word)) ?
                     fac_pkg::byte_merge(fill_k, sv_data_r, sv_mask_r) : fill_k;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_found = 1'b0;
    free_idx = '0;
    for (int i = LN - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == tag_in)) begin
        hit = 1'b1;
        hit_idx = LW'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx = LW'(i);
      end
    end
  end

  assign line_sel = free_found ? free_idx : lfsr_step[LW-1:0];

  always_comb begin
    s1_done   = 1'b0;
    emit      = 1'b0;
    res       = '0;
    res_mem   = 1'b0;
    mreq      = '0;
    miss_nxt  = miss_r;
    beat_nxt  = beat_r;
    seq_nxt   = seq_r;
    valid_nxt = valid_r;
    lfsr_nxt  = lfsr_r;
    save_en   = 1'b0;
    fill_en   = 1'b0;
    tag_en    = 1'b0;
    if (!s1_valid_r) begin
      s1_done = 1'b1;
    end else if (is_cpu) begin
      res.out_port = s1_r.port;
      res.last     = 1'b1;
      if (!port_ok) begin
        s1_done = 1'b1;
      end else if (miss_r) begin
        emit = 1'b1;
        res.kind = fac_pkg::KIND_REJECT;
        res.out_address = fac_pkg::OUT_AW'({addr_m[AW-1:3], 3'b000});
        s1_done = s2_free;
      end else if (hit) begin
        emit = 1'b1;
        res.kind = fac_pkg::KIND_RESP;
        res.out_address = fac_pkg::OUT_AW'({addr_m[AW-1:3], 3'b000});
        s1_done = s2_free;
        if (s1_r.opcode == fac_pkg::OP_WRITE) begin
          mreq.we    = s2_free;
          mreq.wbe   = s1_r.byte_mask;
          mreq.waddr = {hit_idx, addr_m[fac_pkg::OFF_W-1:3]};
          mreq.wdata = s1_r.data;
        end else begin
          res_mem    = 1'b1;
          mreq.re    = s2_free;
          mreq.raddr = {hit_idx, addr_m[fac_pkg::OFF_W-1:3]};
        end
      end else begin
        emit = 1'b1;
        res.kind = fac_pkg::KIND_BLK_RD;
        res.out_port = '0;
        res.out_address = fac_pkg::OUT_AW'({tag_in, fac_pkg::OFF_W'(0)});
        s1_done = s2_free;
        if (s2_free) begin
          miss_nxt = 1'b1;
          beat_nxt = '0;
          save_en  = 1'b1;
        end
      end
    end else if ((s1_r.opcode != fac_pkg::OP_FILL) || !miss_r) begin
      s1_done = 1'b1;
    end else if (beat_r != WW'(BW - 1)) begin
      fill_en  = 1'b1;
      beat_nxt = beat_r + 1'b1;
      s1_done  = 1'b1;
    end else if (seq_r != (WW + 1)'(BW)) begin
      // install one word per cycle while no victim writeback is stalled, writing back the victim word first
      if (!free_found) begin
        emit = 1'b1;
        res.kind = fac_pkg::KIND_WB;
        res.out_address = fac_pkg::OUT_AW'({tag_r[line_sel], k, 3'b000});
        res_mem = 1'b1;
        mreq.re = s2_free;
        mreq.raddr = {line_sel, k};
      end
      if (free_found || s2_free) begin
        mreq.we    = 1'b1;
        mreq.wbe   = '1;
        mreq.waddr = {line_sel, k};
        mreq.wdata = inst_data;
        seq_nxt    = seq_r + 1'b1;
      end
    end else begin
      emit = 1'b1;
      res.kind = fac_pkg::KIND_RESP;
      res.out_port = sv_port_r;
      res.out_address = fac_pkg::OUT_AW'({sv_addr_r[AW-1:3], 3'b000});
      res.out_data = sv_write_r ? 64'd0 : fill_sv;
      res.last = 1'b1;
      s1_done = s2_free;
      if (s2_free) begin
        tag_en = 1'b1;
        valid_nxt[line_sel] = 1'b1;
        if (!free_found) lfsr_nxt = lfsr_step;
        miss_nxt = 1'b0;
        beat_nxt = '0;
        seq_nxt  = '0;
      end
    end
  end

  assign in_ready     = !s1_valid_r || s1_done;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_done ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      miss_r      <= 1'b0;
      beat_r      <= '0;
      seq_r       <= '0;
      valid_r     <= '0;
      lfsr_r      <= fac_pkg::SEED_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s2_free) out_valid_r <= emit;
      miss_r  <= miss_nxt;
      beat_r  <= beat_nxt;
      seq_r   <= seq_nxt;
      valid_r <= valid_nxt;
      lfsr_r  <= cfg_wr_en ? cfg_wr_data : lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_r <= in_item;
    if (s2_free && emit) begin
      out_r     <= res;
      use_mem_r <= res_mem;
    end
    if (save_en) begin
      sv_port_r  <= s1_r.port;
      sv_write_r <= (s1_r.opcode == fac_pkg::OP_WRITE);
      sv_addr_r  <= addr_m;
      sv_mask_r  <= s1_r.byte_mask;
      sv_data_r  <= s1_r.data;
    end
    if (fill_en) fill_r[beat_r] <= s1_r.data;
    if (tag_en) tag_r[line_sel] <= sv_addr_r[AW-1:fac_pkg::OFF_W];
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_item = out_r;
    if (use_mem_r) out_item.out_data = mem_rdata;
  end

  a_wb_in_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == fac_pkg::KIND_WB)) |-> miss_r)
    else $error("writeback beat outside a miss");
  a_seq_held: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != '0) |-> (s1_valid_r && miss_r))
    else $error("install sequence without a held last beat");
  a_beat_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != '0) |-> miss_r)
    else $error("fill count moved while idle");
  a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == fac_pkg::KIND_WB)) |-> !out_r.last)
    else $error("writeback beat marked last");

endmodule

// File: design/fac_line_mem.sv
module fac_line_mem (
  input  logic              clk,
  input  fac_pkg::mem_req_t req,
  output logic [63:0]       rdata
);

  logic [63:0] mem [fac_pkg::LINES * fac_pkg::BLOCK_WORDS];
  logic [63:0] rdata_r;

  // byte lanes written separately, read returns the old word on a collision
  always_ff @(posedge clk) begin
    if (req.we) begin
      for (int b = 0; b < 8; b++) begin
        if (req.wbe[b]) mem[req.waddr][8*b +: 8] <= req.wdata[8*b +: 8];
      end
    end
    if (req.re) rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = fac_pkg::BLOCK_WORDS + 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fac_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fac_pkg::out_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  fully_assoc_writeback_cache u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cache image kept by the predictor
  logic [25:0] tag_of[fac_pkg::LINES];
  logic        line_ok[fac_pkg::LINES];
  logic [63:0] word_of[fac_pkg::LINES*fac_pkg::BLOCK_WORDS];
  logic [63:0] fill_buf[fac_pkg::BLOCK_WORDS];
  int          beat_no;
  logic        miss_open;
  logic [1:0]  miss_port;
  logic        miss_wr;
  logic [31:0] miss_addr;
  logic [7:0]  miss_mask;
  logic [63:0] miss_data;
  logic [15:0] lfsr;

  fac_pkg::in_t  pending_items[$];
  fac_pkg::out_t expected_results[$];
  logic [25:0] tag_pool[24];
  int   errors = 0;
  int   cycles = 0;
  logic burst = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;

  function automatic void serve(int ln, logic [31:0] a, logic wr, logic [7:0] m,
                                logic [63:0] d, logic [1:0] p);
    fac_pkg::out_t r;
    int   w;
    w = ln * fac_pkg::BLOCK_WORDS + a[5:3];
    r = '0;
    r.kind = fac_pkg::KIND_RESP;
    r.out_port = p;
    r.out_address = {a[31:3], 3'b000};
    r.last = 1'b1;
    if (wr) begin
      for (int b = 0; b < 8; b++)
        if (m[b]) word_of[w][8*b +: 8] = d[8*b +: 8];
    end else begin
      r.out_data = word_of[w];
    end
    expected_results.push_back(r);
  endfunction

  function automatic void predict(fac_pkg::in_t it);
    fac_pkg::out_t r;
    int   ln;
    r = '0;
    ln = -1;
    case (it.opcode)
      fac_pkg::OP_READ, fac_pkg::OP_WRITE: begin
        if (miss_open) begin
          r.kind = fac_pkg::KIND_REJECT;
          r.out_port = it.port;
          r.out_address = {it.address[31:3], 3'b000};
          r.last = 1'b1;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < fac_pkg::LINES; i++)
            if (ln < 0 && line_ok[i] && tag_of[i] == it.address[31:6]) ln = i;
          if (ln >= 0) begin
            serve(ln, it.address, it.opcode == fac_pkg::OP_WRITE, it.byte_mask, it.data,
                  it.port);
          end else begin
            miss_open = 1'b1;
            beat_no = 0;
            miss_port = it.port;
            miss_wr = (it.opcode == fac_pkg::OP_WRITE);
            miss_addr = it.address;
            miss_mask = it.byte_mask;
            miss_data = it.data;
            r.kind = fac_pkg::KIND_BLK_RD;
            r.out_address = {it.address[31:6], 6'b0};
            r.last = 1'b1;
            expected_results.push_back(r);
          end
        end
      end
      fac_pkg::OP_FILL: begin
        if (miss_open) begin
          fill_buf[beat_no] = it.data;
          if (beat_no < fac_pkg::BLOCK_WORDS - 1) begin
            beat_no++;
          end else begin
            for (int i = 0; i < fac_pkg::LINES; i++)
              if (ln < 0 && !line_ok[i]) ln = i;
            if (ln < 0) begin
              // every line in use: step the lfsr and evict its pick, dirty or not
              lfsr = lfsr[0] ? ((lfsr >> 1) ^ fac_pkg::LFSR_TAPS) : (lfsr >> 1);
              ln = lfsr[fac_pkg::LINE_W-1:0];
              for (int i = 0; i < fac_pkg::BLOCK_WORDS; i++) begin
                r = '0;
                r.kind = fac_pkg::KIND_WB;
                r.out_address = {tag_of[ln], 6'b0} + 32'(8 * i);
                r.out_data = word_of[ln*fac_pkg::BLOCK_WORDS + i];
                expected_results.push_back(r);
              end
            end
            tag_of[ln] = miss_addr[31:6];
            line_ok[ln] = 1'b1;
            for (int i = 0; i < fac_pkg::BLOCK_WORDS; i++)
              word_of[ln*fac_pkg::BLOCK_WORDS + i] = fill_buf[i];
            serve(ln, miss_addr, miss_wr, miss_mask, miss_data, miss_port);
            miss_open = 1'b0;
            beat_no = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] op, logic [1:0] p, logic [31:0] a,
                                     logic [7:0] m, logic [63:0] d);
    fac_pkg::in_t it;
    it.opcode = op;
    it.port = p;
    it.address = a;
    it.byte_mask = m;
    it.data = d;
    predict(it);
    pending_items.push_back(it);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void random_items(int n);
    int k;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4) begin
        queue_item(fac_pkg::OP_NONE, 2'($urandom()), $urandom(), 8'($urandom()), rand64());
      end else if (miss_open ? (k < 88) : (k < 12)) begin
        queue_item(fac_pkg::OP_FILL, 2'($urandom()), $urandom(), 8'($urandom()), rand64());
      end else begin
        op = $urandom_range(0, 1) ? fac_pkg::OP_WRITE : fac_pkg::OP_READ;
        queue_item(op, 2'($urandom()), {tag_pool[$urandom_range(0, 23)], 6'(($urandom()))},
                   8'($urandom()), rand64());
      end
    end
  endfunction

  task automatic drain_and_seed(logic [15:0] s);
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    lfsr = s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the item
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      if ($urandom_range(0, 19) == 0) burst = !burst;
      in_gap <= burst ? 0 : $urandom_range(0, 9);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    fac_pkg::out_t e;
    int   d;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected item: got %h", $time, out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.kind != e.kind)
          $display("%0t kind: expected %0d got %0d", $time, e.kind, out_item.kind);
        if (out_item.out_port != e.out_port)
          $display("%0t port: expected %0d got %0d", $time, e.out_port, out_item.out_port);
        if (out_item.out_address != e.out_address)
          $display("%0t address: expected %h got %h", $time, e.out_address,
                   out_item.out_address);
        if (out_item.out_data != e.out_data)
          $display("%0t data: expected %h got %h", $time, e.out_data, out_item.out_data);
        if (out_item.last != e.last)
          $display("%0t last: expected %0d got %0d", $time, e.last, out_item.last);
        if (out_item != e) errors++;
      end
      d = burst ? 0 : $urandom_range(0, 9);
      out_stall <= d;
      out_ready <= (d == 0);
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < fac_pkg::LINES; i++) line_ok[i] = 1'b0;
    miss_open = 1'b0;
    beat_no = 0;
    lfsr = fac_pkg::SEED_RESET;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 24; i++) tag_pool[i] = 26'($urandom());
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill while idle, miss at the lowest and highest address, hits, rejects
    queue_item(fac_pkg::OP_FILL, 2'd0, 32'h0, 8'h00, 64'h0);
    queue_item(fac_pkg::OP_NONE, 2'd3, '1, '1, '1);
    queue_item(fac_pkg::OP_WRITE, 2'd0, 32'h0000_0005, 8'hFF, '1);
    queue_item(fac_pkg::OP_READ, 2'd3, '1, 8'h00, 64'h0);
    for (int i = 0; i < fac_pkg::BLOCK_WORDS; i++)
      queue_item(fac_pkg::OP_FILL, 2'd0, 32'h0, 8'h0, (i == 0) ? 64'h0 : rand64());
    queue_item(fac_pkg::OP_READ, 2'd1, 32'h0000_0003, 8'h00, 64'h0);
    queue_item(fac_pkg::OP_WRITE, 2'd2, 32'h0000_0038, 8'h00, '1);
    queue_item(fac_pkg::OP_WRITE, 2'd3, 32'h0000_0038, 8'hA5, 64'h0);
    queue_item(fac_pkg::OP_READ, 2'd3, 32'h0000_003F, 8'hFF, 64'h0);
    queue_item(fac_pkg::OP_READ, 2'd2, '1, 8'h00, 64'h0);
    for (int i = 0; i < fac_pkg::BLOCK_WORDS; i++)
      queue_item(fac_pkg::OP_FILL, 2'd0, 32'h0, 8'h0,
                 (i == fac_pkg::BLOCK_WORDS - 1) ? '1 : rand64());
    random_items(80);

    drain_and_seed(16'hFFFF);
    random_items(80);
    drain_and_seed(16'h0001);
    random_items(80);
    drain_and_seed(16'h0000);
    random_items(60);
    drain_and_seed(16'($urandom()));
    random_items(80);

    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
